FILE: design/mfe_pkg.sv
// ---------------------------------------------------------------------------
// mfe_pkg
// Shared types and constants of the monochrome frame buffer engine.
// ---------------------------------------------------------------------------
package mfe_pkg;

    localparam int PAGE_COUNT_DEF   = 8;
    localparam int COLUMN_COUNT_DEF = 128;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic [7:0] PAGE_BASE_RESET = 8'd176;
    localparam logic [7:0] BYTE_ONES       = 8'hFF;
    localparam logic [7:0] BYTE_ZERO       = 8'h00;

    localparam logic [2:0] CMD_WIPE  = 3'd0;
    localparam logic [2:0] CMD_FLUSH = 3'd1;
    localparam logic [2:0] CMD_BYTE  = 3'd2;
    localparam logic [2:0] CMD_POINT = 3'd3;
    localparam logic [2:0] CMD_BLOCK = 3'd4;

    localparam logic [1:0] MODE_SET  = 2'd0;
    localparam logic [1:0] MODE_OR   = 2'd1;
    localparam logic [1:0] MODE_CLR  = 2'd2;
    localparam logic [1:0] MODE_KEEP = 2'd3;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic modify_wr;
        logic block_step;
        logic flush_load;
    } t_ctrl;

    typedef struct packed {
        logic sweep_last;
        logic block_last;
        logic out_free;
    } t_status;

endpackage

FILE: design/mfe_ctrl.sv
// ---------------------------------------------------------------------------
// mfe_ctrl
// Command sequencer: clear sweep, read-modify-write, block fill, flush.
// ---------------------------------------------------------------------------
module mfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2:0]      i_cmd,
    input  mfe_pkg::t_status i_status,
    output logic            o_ready,
    output mfe_pkg::t_ctrl  o_ctrl
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_MODIFY = 3'd2;
    localparam logic [2:0] S_BLOCK  = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = o_ready && i_valid;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_ctrl.accept = accept;
        unique case (r_state)
            S_CLEAR: begin
                o_ctrl.clear_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        mfe_pkg::CMD_WIPE:  n_state = S_CLEAR;
                        mfe_pkg::CMD_FLUSH: n_state = S_FLUSH;
                        mfe_pkg::CMD_BYTE,
                        mfe_pkg::CMD_POINT: n_state = S_MODIFY;
                        mfe_pkg::CMD_BLOCK: n_state = S_BLOCK;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_MODIFY: begin
                o_ctrl.modify_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_BLOCK: begin
                o_ctrl.block_step = 1'b1;
                if (i_status.block_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_ctrl.flush_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/mfe_dp.sv
// ---------------------------------------------------------------------------
// mfe_dp
// Frame store, item registers, flush position and output register.
// ---------------------------------------------------------------------------
module mfe_dp #(
    parameter int PAGE_COUNT   = mfe_pkg::PAGE_COUNT_DEF,
    parameter int COLUMN_COUNT = mfe_pkg::COLUMN_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mfe_pkg::t_ctrl   i_ctrl,
    output mfe_pkg::t_status o_status,
    input  logic [2:0]       i_cmd,
    input  logic [5:0]       i_row,
    input  logic [6:0]       i_col,
    input  logic [7:0]       i_data,
    input  logic [1:0]       i_mode,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_out_is_cmd,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    localparam int DEPTH = PAGE_COUNT * COLUMN_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CW    = $clog2(COLUMN_COUNT);
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMN_COUNT);
    localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
    localparam logic [PW-1:0] LAST_PG  = PW'(PAGE_COUNT - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLUMN_COUNT - 1);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic [7:0]    r_page_base;

    logic [AW-1:0] r_sweep;
    logic [2:0]    r_bcnt;

    logic [AW-1:0] r_addr;
    logic          r_hit;
    logic [7:0]    r_mask;
    logic [1:0]    r_mode;
    logic [5:0]    r_page6;
    logic [6:0]    r_col;

    logic [PW-1:0] r_fpage;
    logic [CW-1:0] r_fcol;
    logic          r_fsent;

    logic          r_out_valid;
    logic          r_out_is_cmd;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic [5:0]    in_page6;
    logic [8:0]    in_col9;
    logic [7:0]    in_mask;
    logic          in_hit;
    logic [PW-1:0] in_page;
    logic [CW-1:0] in_colc;
    logic [AW-1:0] in_addr;
    logic [AW-1:0] flush_addr;
    logic [AW-1:0] rd_addr;

    logic [9:0]    blk_col10;
    logic          blk_hit;
    logic [AW-1:0] blk_addr;
    logic [7:0]    blk_byte;

    logic [7:0]    mod_byte;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_byte;
    logic          page_end;

    // target of a byte or point draw, taken from the incoming transaction
    always_comb begin
        in_page6 = (i_cmd == mfe_pkg::CMD_POINT) ? {3'b000, i_row[5:3]} : i_row;
        in_col9  = {2'b00, i_col};
        in_mask  = (i_cmd == mfe_pkg::CMD_POINT) ? (8'd1 << i_row[2:0]) : i_data;
        in_hit   = (in_page6 < 6'(PAGE_COUNT)) && (in_col9 < 9'(COLUMN_COUNT))
                   && (i_mode != mfe_pkg::MODE_KEEP);
        in_page  = PW'(in_page6);
        in_colc  = CW'(in_col9);
        in_addr  = AW'(in_page) * COLS_A + AW'(in_colc);
    end

    assign flush_addr = AW'(r_fpage) * COLS_A + AW'(r_fcol);
    assign rd_addr    = (i_cmd == mfe_pkg::CMD_FLUSH) ? flush_addr : in_addr;

    always_comb begin
        blk_col10 = {r_col, r_bcnt};
        blk_hit   = (r_page6 < 6'(PAGE_COUNT)) && (blk_col10 < 10'(COLUMN_COUNT))
                    && (r_mode != mfe_pkg::MODE_KEEP);
        blk_addr  = AW'(PW'(r_page6)) * COLS_A + AW'(CW'(blk_col10));
        blk_byte  = (r_mode == mfe_pkg::MODE_CLR) ? mfe_pkg::BYTE_ZERO : mfe_pkg::BYTE_ONES;
    end

    always_comb begin
        case (r_mode)
            mfe_pkg::MODE_SET: mod_byte = r_mask;
            mfe_pkg::MODE_OR:  mod_byte = r_rdata | r_mask;
            mfe_pkg::MODE_CLR: mod_byte = r_rdata & ~r_mask;
            default:           mod_byte = r_rdata;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_byte = mod_byte;
        if (i_ctrl.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = r_sweep;
            wr_byte = mfe_pkg::BYTE_ZERO;
        end else if (i_ctrl.block_step) begin
            wr_en   = blk_hit;
            wr_addr = blk_addr;
            wr_byte = blk_byte;
        end else if (i_ctrl.modify_wr) begin
            wr_en   = r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_byte;
        end
        if (i_ctrl.accept) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_addr  <= in_addr;
            r_hit   <= in_hit;
            r_mask  <= in_mask;
            r_mode  <= i_mode;
            r_page6 <= i_row;
            r_col   <= i_col;
        end
        if (i_ctrl.flush_load) begin
            r_out_is_cmd <= !r_fsent;
            r_out_byte   <= r_fsent ? r_rdata : 8'(r_page_base + 8'(r_fpage));
            r_out_last   <= r_fsent && page_end && (r_fpage == LAST_PG);
        end
    end

    assign page_end = (r_fcol == LAST_COL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_base <= mfe_pkg::PAGE_BASE_RESET;
            r_sweep     <= '0;
            r_bcnt      <= '0;
            r_fpage     <= '0;
            r_fcol      <= '0;
            r_fsent     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_page_base <= i_cfg_wr_data;
            end
            if (i_ctrl.clear_step) begin
                r_sweep <= (r_sweep == LAST_A) ? '0 : r_sweep + AW'(1);
            end
            if (i_ctrl.block_step) begin
                r_bcnt <= r_bcnt + 3'd1;
            end
            if (i_ctrl.flush_load) begin
                r_out_valid <= 1'b1;
                if (!r_fsent) begin
                    r_fsent <= 1'b1;
                end else if (page_end) begin
                    r_fcol  <= '0;
                    r_fsent <= 1'b0;
                    r_fpage <= (r_fpage == LAST_PG) ? '0 : r_fpage + PW'(1);
                end else begin
                    r_fcol <= r_fcol + CW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.sweep_last = (r_sweep == LAST_A);
    assign o_status.block_last = (r_bcnt == 3'd7);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_is_cmd = r_out_is_cmd;
    assign o_out_byte   = r_out_byte;
    assign o_out_last   = r_out_last;

endmodule

FILE: design/monochrome_framebuffer_engine.sv
// ---------------------------------------------------------------------------
// monochrome_framebuffer_engine
// Page-organized monochrome frame store with draw commands and a display
// stream. One transaction per command. Draw byte and draw point read the
// store, then write; a flush step reads the store, then waits on any result
// still held in the output register; draw block writes eight columns (one
// write per column), wipe zeroes every entry, commands 5 to 7 do nothing.
// After reset a clearing pass over PAGE_COUNT*COLUMN_COUNT entries (1024 by
// default) zeroes the store while s_axis_tready stays low, one entry per
// cycle through the single store port.
// ---------------------------------------------------------------------------
module monochrome_framebuffer_engine #(
    parameter int PAGE_COUNT   = mfe_pkg::PAGE_COUNT_DEF,
    parameter int COLUMN_COUNT = mfe_pkg::COLUMN_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [7:0]                    i_cfg_wr_data,  // page_command_base
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // command[2:0], row_position[8:3], column[15:9], data_byte[23:16],
    // draw_mode[25:24], zero fill
    input  logic [mfe_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mfe_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_byte[7:0]
    output logic                          m_axis_tuser,  // is_command[0]
    output logic                          m_axis_tlast
);

    mfe_pkg::t_ctrl   ctrl;
    mfe_pkg::t_status status;

    mfe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_cmd    (s_axis_tdata[2:0]),
        .i_status (status),
        .o_ready  (s_axis_tready),
        .o_ctrl   (ctrl)
    );

    mfe_dp #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_status      (status),
        .i_cmd         (s_axis_tdata[2:0]),
        .i_row         (s_axis_tdata[8:3]),
        .i_col         (s_axis_tdata[15:9]),
        .i_data        (s_axis_tdata[23:16]),
        .i_mode        (s_axis_tdata[25:24]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_is_cmd  (m_axis_tuser),
        .o_out_byte    (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

endmodule

FILE: design/mfe_checker.sv
// ---------------------------------------------------------------------------
// mfe_checker
// Port-level checks of the frame buffer engine, bound to the top level.
// ---------------------------------------------------------------------------
module mfe_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mfe_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mfe_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser,
    input logic                          m_axis_tlast
);

    // store is being cleared right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("input ready during clearing pass");

    // any real command makes the engine busy, so s_axis_tready drops once it is taken
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready &&
         (s_axis_tdata[2:0] == mfe_pkg::CMD_WIPE  ||
          s_axis_tdata[2:0] == mfe_pkg::CMD_FLUSH ||
          s_axis_tdata[2:0] == mfe_pkg::CMD_BYTE  ||
          s_axis_tdata[2:0] == mfe_pkg::CMD_POINT ||
          s_axis_tdata[2:0] == mfe_pkg::CMD_BLOCK)) |=> !s_axis_tready)
        else $error("ready right after a command transaction");

    // frame end is always a data byte
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser)
        else $error("tlast on a page command byte");

    // a page command byte follows the frame end
    a_cmd_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
        (!m_axis_tvalid || m_axis_tuser))
        else $error("data byte directly after frame end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("output changed while stalled");

endmodule

bind monochrome_framebuffer_engine mfe_checker u_mfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
